@@ src/rrts_pkg.sv @@
// ----------------------------------------------------------------------------
// rrts_pkg
// Shared types, codes and sizes for the round-robin task scheduler.
// ----------------------------------------------------------------------------
package rrts_pkg;

  localparam int MAX_TASKS = 8;
  localparam int IDX_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W     = $clog2(MAX_TASKS + 1);
  localparam int DLY_W     = 32;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [2:0] {
    ACT_INIT   = 3'd0,
    ACT_CREATE = 3'd1,
    ACT_START  = 3'd2,
    ACT_TICK   = 3'd3,
    ACT_DELAY  = 3'd4,
    ACT_EXIT   = 3'd5,
    ACT_SWITCH = 3'd6,
    ACT_BAD    = 3'd7
  } act_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_ISR       = 3'd1,
    ST_BAD_STATE = 3'd2,
    ST_BAD_ARG   = 3'd3,
    ST_NO_SLOTS  = 3'd4,
    ST_IRQ_OFF   = 3'd5
  } stat_t;

  typedef enum logic [1:0] {
    TS_TERMINATED = 2'd0,
    TS_READY      = 2'd1,
    TS_RUNNING    = 2'd2,
    TS_BLOCKED    = 2'd3
  } ts_t;

  typedef enum logic [1:0] {
    PH_UNINIT  = 2'd0,
    PH_INIT    = 2'd1,
    PH_RUNNING = 2'd2
  } phase_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_INIT,
    S_TICK_RD,
    S_TICK_WR,
    S_SCHED,
    S_SEARCH,
    S_FIX,
    S_DONE
  } state_t;

  // task index on a 3-bit result field
  function automatic logic [2:0] idx3(input idx_t v);
    logic [IDX_W+2:0] w;
    w = {3'b000, v};
    return w[2:0];
  endfunction

endpackage

@@ src/rrts_ram.sv @@
// ----------------------------------------------------------------------------
// rrts_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rrts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/round_robin_task_scheduler.sv @@
// Init walks the whole task table; tick sweeps the live entries, then searches;
// a delay that blocks and an exit also search; the other actions end after decode.
// One word in process at a time; the next word is taken once its result is registered.
// A result waiting on out_ready holds back only the next result, not the input.
// The delay countdown sweep (a read state, then a write state, per entry) and
// the round-robin search (one entry a cycle) walk the task table through a single index/compare unit.
// Reset (rst, synchronous) clears phase, counters and task states; countdowns are written before use.
// ----------------------------------------------------------------------------
// round_robin_task_scheduler
// Task-table scheduler: init, create, start, tick, delay, exit, switch done.
// ----------------------------------------------------------------------------
module round_robin_task_scheduler (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  action,
  input  logic [31:0] delay_ticks,
  input  logic        entry_present,
  input  logic        in_interrupt,
  input  logic        interrupts_off,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [2:0]  new_task_index,
  output logic [2:0]  chosen_task,
  output logic        switch_request,
  output logic [31:0] tick_total,
  output logic [1:0]  run_phase
);

  rrts_pkg::state_t state, state_next;
  rrts_pkg::phase_t phase, phase_next;
  rrts_pkg::cnt_t   task_total, task_total_next;
  rrts_pkg::idx_t   current_task, current_task_next;
  rrts_pkg::idx_t   next_task, next_task_next;
  rrts_pkg::ts_t [rrts_pkg::MAX_TASKS-1:0] task_status, task_status_next;
  logic [rrts_pkg::MAX_TASKS-1:0] waiting, waiting_next;
  logic [31:0]      tick_counter, tick_counter_next;
  rrts_pkg::idx_t   idx, idx_next;
  rrts_pkg::cnt_t   cnt, cnt_next;
  rrts_pkg::idx_t   pick, pick_next;
  logic             out_valid_next;
  rrts_pkg::stat_t  st, st_next;
  rrts_pkg::idx_t   new_idx, new_idx_next;
  logic             sw, sw_next;

  rrts_pkg::act_t   act;
  logic [31:0]      ticks;
  logic             entry, isr, irq_off;

  logic             ram_we;
  rrts_pkg::idx_t   ram_waddr;
  logic [31:0]      ram_wdata;
  logic [31:0]      ram_rdata;

  rrts_pkg::ts_t    rd_st;
  logic             rd_wait;
  rrts_pkg::idx_t   idx_wrap;
  rrts_pkg::idx_t   cur_wrap;
  logic             accept;
  logic             load_out;

  assign in_ready = (state == rrts_pkg::S_IDLE);
  assign accept   = in_valid && in_ready;
  assign load_out = (state == rrts_pkg::S_DONE) && (!out_valid || out_ready);
  assign rd_st    = task_status[idx];
  assign rd_wait  = waiting[idx];

  // round-robin successor within the live part of the table
  assign idx_wrap = (rrts_pkg::CNT_W'(idx) + 1'b1 >= task_total) ?
                    '0 : idx + 1'b1;
  assign cur_wrap = (rrts_pkg::CNT_W'(current_task) + 1'b1 >= task_total) ?
                    '0 : current_task + 1'b1;

  rrts_ram #(
    .WIDTH(rrts_pkg::DLY_W),
    .DEPTH(rrts_pkg::MAX_TASKS)
  ) u_delay_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(idx),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      act     <= rrts_pkg::act_t'(action);
      ticks   <= delay_ticks;
      entry   <= entry_present;
      isr     <= in_interrupt;
      irq_off <= interrupts_off;
    end
    if (load_out) begin
      status         <= st;
      new_task_index <= rrts_pkg::idx3(new_idx);
      chosen_task    <= rrts_pkg::idx3(next_task);
      switch_request <= sw;
      tick_total     <= tick_counter;
      run_phase      <= phase;
    end
    idx     <= idx_next;
    cnt     <= cnt_next;
    pick    <= pick_next;
    st      <= st_next;
    new_idx <= new_idx_next;
    sw      <= sw_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= rrts_pkg::S_IDLE;
      phase        <= rrts_pkg::PH_UNINIT;
      task_total   <= '0;
      current_task <= '0;
      next_task    <= '0;
      waiting      <= '0;
      tick_counter <= '0;
      out_valid    <= 1'b0;
      for (int k = 0; k < rrts_pkg::MAX_TASKS; k++) begin
        task_status[k] <= rrts_pkg::TS_TERMINATED;
      end
    end else begin
      state        <= state_next;
      phase        <= phase_next;
      task_total   <= task_total_next;
      current_task <= current_task_next;
      next_task    <= next_task_next;
      waiting      <= waiting_next;
      tick_counter <= tick_counter_next;
      out_valid    <= out_valid_next;
      task_status  <= task_status_next;
    end
  end

  always_comb begin
    state_next        = state;
    phase_next        = phase;
    task_total_next   = task_total;
    current_task_next = current_task;
    next_task_next    = next_task;
    task_status_next  = task_status;
    waiting_next      = waiting;
    tick_counter_next = tick_counter;
    idx_next          = idx;
    cnt_next          = cnt;
    pick_next         = pick;
    st_next           = st;
    new_idx_next      = new_idx;
    sw_next           = sw;
    out_valid_next    = out_valid && !out_ready;
    ram_we            = 1'b0;
    ram_waddr         = current_task;
    ram_wdata         = ticks;

    unique case (state)
      rrts_pkg::S_IDLE: begin
        if (accept) begin
          st_next      = rrts_pkg::ST_OK;
          new_idx_next = '0;
          sw_next      = 1'b0;
          state_next   = rrts_pkg::S_DECODE;
        end
      end

      rrts_pkg::S_DECODE: begin
        state_next = rrts_pkg::S_DONE;
        unique case (act)
          rrts_pkg::ACT_INIT: begin
            if (isr) begin
              st_next = rrts_pkg::ST_ISR;
            end else if (phase != rrts_pkg::PH_UNINIT) begin
              st_next = rrts_pkg::ST_BAD_STATE;
            end else begin
              idx_next   = '0;
              state_next = rrts_pkg::S_INIT;
            end
          end
          rrts_pkg::ACT_CREATE: begin
            if (isr) begin
              st_next = rrts_pkg::ST_ISR;
            end else if (phase != rrts_pkg::PH_INIT) begin
              st_next = rrts_pkg::ST_BAD_STATE;
            end else if (!entry) begin
              st_next = rrts_pkg::ST_BAD_ARG;
            end else if (task_total >= rrts_pkg::CNT_W'(rrts_pkg::MAX_TASKS)) begin
              st_next = rrts_pkg::ST_NO_SLOTS;
            end else begin
              new_idx_next = rrts_pkg::IDX_W'(task_total);
              task_status_next[rrts_pkg::IDX_W'(task_total)] = rrts_pkg::TS_READY;
              waiting_next[rrts_pkg::IDX_W'(task_total)]     = 1'b0;
              task_total_next = task_total + 1'b1;
            end
          end
          rrts_pkg::ACT_START: begin
            if (isr) begin
              st_next = rrts_pkg::ST_ISR;
            end else if (phase != rrts_pkg::PH_INIT) begin
              st_next = rrts_pkg::ST_BAD_STATE;
            end else begin
              phase_next = rrts_pkg::PH_RUNNING;
            end
          end
          rrts_pkg::ACT_TICK: begin
            if (phase == rrts_pkg::PH_RUNNING) begin
              tick_counter_next = tick_counter + 32'd1;
              idx_next          = '0;
              state_next        = (task_total == '0) ? rrts_pkg::S_SCHED :
                                                       rrts_pkg::S_TICK_RD;
            end
          end
          rrts_pkg::ACT_DELAY: begin
            if (ticks == 32'd0) begin
              st_next = rrts_pkg::ST_OK;
            end else if (phase != rrts_pkg::PH_RUNNING) begin
              st_next = rrts_pkg::ST_BAD_STATE;
            end else if (isr) begin
              st_next = rrts_pkg::ST_ISR;
            end else if (irq_off) begin
              st_next = rrts_pkg::ST_IRQ_OFF;
            end else begin
              ram_we = 1'b1;
              task_status_next[current_task] = rrts_pkg::TS_BLOCKED;
              waiting_next[current_task]     = 1'b1;
              sw_next    = 1'b1;
              state_next = rrts_pkg::S_SCHED;
            end
          end
          rrts_pkg::ACT_EXIT: begin
            task_status_next[current_task] = rrts_pkg::TS_TERMINATED;
            waiting_next[current_task]     = 1'b0;
            sw_next    = 1'b1;
            state_next = rrts_pkg::S_SCHED;
          end
          rrts_pkg::ACT_SWITCH: begin
            current_task_next = next_task;
          end
          default: begin
            st_next = rrts_pkg::ST_BAD_ARG;
          end
        endcase
      end

      rrts_pkg::S_INIT: begin
        task_status_next[idx] = (idx == '0) ? rrts_pkg::TS_RUNNING :
                                              rrts_pkg::TS_TERMINATED;
        waiting_next[idx] = 1'b0;
        if (idx == rrts_pkg::IDX_W'(rrts_pkg::MAX_TASKS - 1)) begin
          current_task_next = '0;
          next_task_next    = '0;
          task_total_next   = rrts_pkg::CNT_W'(1);
          phase_next        = rrts_pkg::PH_INIT;
          state_next        = rrts_pkg::S_DONE;
        end else begin
          idx_next = idx + 1'b1;
        end
      end

      rrts_pkg::S_TICK_RD: begin
        state_next = rrts_pkg::S_TICK_WR;
      end

      rrts_pkg::S_TICK_WR: begin
        if (rd_st == rrts_pkg::TS_BLOCKED && rd_wait && ram_rdata != 32'd0) begin
          ram_we    = 1'b1;
          ram_waddr = idx;
          ram_wdata = ram_rdata - 32'd1;
          if (ram_rdata == 32'd1) begin
            waiting_next[idx]     = 1'b0;
            task_status_next[idx] = rrts_pkg::TS_READY;
          end
        end
        if (rrts_pkg::CNT_W'(idx) + 1'b1 >= task_total) begin
          state_next = rrts_pkg::S_SCHED;
        end else begin
          idx_next   = idx + 1'b1;
          state_next = rrts_pkg::S_TICK_RD;
        end
      end

      rrts_pkg::S_SCHED: begin
        if (task_total == '0) begin
          if (act == rrts_pkg::ACT_TICK) begin
            sw_next = (next_task != current_task);
          end
          state_next = rrts_pkg::S_DONE;
        end else begin
          idx_next   = cur_wrap;
          cnt_next   = '0;
          state_next = rrts_pkg::S_SEARCH;
        end
      end

      rrts_pkg::S_SEARCH: begin
        if (idx != '0 && (rd_st == rrts_pkg::TS_READY || rd_st == rrts_pkg::TS_RUNNING)) begin
          pick_next  = idx;
          idx_next   = current_task;
          state_next = rrts_pkg::S_FIX;
        end else if (cnt + 1'b1 >= task_total) begin
          pick_next  = '0;
          idx_next   = current_task;
          state_next = rrts_pkg::S_FIX;
        end else begin
          cnt_next = cnt + 1'b1;
          idx_next = idx_wrap;
        end
      end

      rrts_pkg::S_FIX: begin
        if (pick != current_task && rd_st == rrts_pkg::TS_RUNNING) begin
          task_status_next[current_task] = rrts_pkg::TS_READY;
        end
        task_status_next[pick] = rrts_pkg::TS_RUNNING;
        next_task_next = pick;
        if (act == rrts_pkg::ACT_TICK) begin
          sw_next = (pick != current_task);
        end
        state_next = rrts_pkg::S_DONE;
      end

      rrts_pkg::S_DONE: begin
        if (load_out) begin
          out_valid_next = 1'b1;
          state_next     = rrts_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = rrts_pkg::S_IDLE;
      end
    endcase
  end

  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    task_total <= rrts_pkg::CNT_W'(rrts_pkg::MAX_TASKS))
    else $error("task_total beyond table size");

  a_cur_live: assert property (@(posedge clk) disable iff (rst)
    task_total != '0 |-> (rrts_pkg::CNT_W'(current_task) < task_total) &&
                         (rrts_pkg::CNT_W'(next_task) < task_total))
    else $error("current or next task outside live table");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    task_total == '0 |-> current_task == '0 && next_task == '0)
    else $error("task index set with empty table");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == rrts_pkg::S_DECODE)
    else $error("accepted word not in process");

  a_done_valid: assert property (@(posedge clk) disable iff (rst)
    state == rrts_pkg::S_DONE |=> out_valid)
    else $error("finished word not presented");

endmodule
